[design/fps_pkg.sv]
// shared types and constants for the flash pulse sequencer
// no dependencies; imported by fps_step, flash_pulse_sequencer_core and tb_top

package fps_pkg;

    // item function codes
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_FIRE = 2'd1;
    localparam logic [1:0] FUNC_SYNC = 2'd2;

    // phase codes, also reported on the phase port
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SETTLE = 2'd1;
    localparam logic [1:0] PH_FIRING = 2'd2;
    localparam logic [1:0] PH_SYNC   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_PULSE = 2'd0;
    localparam logic [1:0] REG_COOLDOWN  = 2'd1;
    localparam logic [1:0] REG_SETTLE    = 2'd2;
    localparam logic [1:0] REG_SYNC_ONLY = 2'd3;

    // register reset values
    localparam logic [7:0]  MAX_PULSE_RST = 8'd20;
    localparam logic [15:0] COOLDOWN_RST  = 16'd1000;
    localparam logic [7:0]  SETTLE_RST    = 8'd5;
    localparam logic [7:0]  SYNC_ONLY_RST = 8'd10;

    // drive level ceiling in percent
    localparam logic [7:0] LEVEL_CAP = 8'd100;

    typedef struct packed {
        logic [7:0]  max_pulse_ms;
        logic [15:0] cooldown_ms;
        logic [7:0]  settle_delay;
        logic [7:0]  sync_only_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  step_left;
        logic [7:0]  pulse_left;
        logic [15:0] cooldown_left;
        logic [6:0]  level;
        logic        sync;
    } seq_state_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] pulse_ms;
        logic [7:0] level_pct;
        logic       sync_req;
    } item_t;

endpackage

[design/fps_step.sv]
// next-state logic of the flash sequencer for one item
// depends on fps_pkg for the state, item and config types

module fps_step
    import fps_pkg::*;
(
    input  seq_state_t cur,
    input  item_t      item,
    input  cfg_t       cfg,
    output seq_state_t nxt,
    output logic       accepted
);

    logic [7:0]  step_dec;
    logic [7:0]  pulse_dec;
    logic [15:0] cool_dec;
    logic [7:0]  len_clamped;
    logic [6:0]  level_clamped;

    // saturating countdowns
    assign step_dec  = (cur.step_left != 8'd0) ? cur.step_left - 8'd1 : 8'd0;
    assign pulse_dec = (cur.pulse_left != 8'd0) ? cur.pulse_left - 8'd1 : 8'd0;
    assign cool_dec  = (cur.cooldown_left != 16'd0) ? cur.cooldown_left - 16'd1 : 16'd0;

    // request clamps
    assign len_clamped   = (item.pulse_ms > cfg.max_pulse_ms) ? cfg.max_pulse_ms
                                                              : item.pulse_ms;
    assign level_clamped = (item.level_pct > LEVEL_CAP) ? LEVEL_CAP[6:0]
                                                        : item.level_pct[6:0];

    always_comb
    begin
        nxt      = cur;
        accepted = 1'b0;
        case (item.func)
            FUNC_TICK:
            begin
                nxt.cooldown_left = cool_dec;
                case (cur.phase)
                    PH_SETTLE:
                    begin
                        nxt.step_left  = step_dec;
                        nxt.pulse_left = pulse_dec;
                        if (step_dec == 8'd0)
                        begin
                            nxt.sync  = 1'b1;
                            nxt.phase = PH_FIRING;
                        end
                    end
                    PH_FIRING:
                    begin
                        nxt.pulse_left = pulse_dec;
                        // pulse over: lights off and cooldown starts
                        if (pulse_dec == 8'd0)
                        begin
                            nxt.level         = 7'd0;
                            nxt.sync          = 1'b0;
                            nxt.cooldown_left = cfg.cooldown_ms;
                            nxt.phase         = PH_IDLE;
                        end
                    end
                    PH_SYNC:
                    begin
                        nxt.step_left = step_dec;
                        if (step_dec == 8'd0)
                        begin
                            nxt.sync  = 1'b0;
                            nxt.phase = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            FUNC_FIRE:
            begin
                if (cur.phase == PH_IDLE && cur.cooldown_left == 16'd0
                    && item.pulse_ms != 8'd0 && item.level_pct != 8'd0)
                begin
                    accepted       = 1'b1;
                    nxt.level      = level_clamped;
                    nxt.pulse_left = len_clamped;
                    // sync after settle only if the flash outlasts the settle time
                    if (item.sync_req && len_clamped > cfg.settle_delay)
                    begin
                        nxt.step_left = cfg.settle_delay;
                        nxt.phase     = PH_SETTLE;
                    end
                    else
                    begin
                        if (item.sync_req)
                            nxt.sync = 1'b1;
                        nxt.phase = PH_FIRING;
                    end
                end
            end
            FUNC_SYNC:
            begin
                // not held off by cooldown
                if (cur.phase == PH_IDLE)
                begin
                    accepted      = 1'b1;
                    nxt.sync      = 1'b1;
                    nxt.step_left = cfg.sync_only_ms;
                    nxt.phase     = PH_SYNC;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[design/flash_pulse_sequencer_core.sv]
// flash pulse sequencer: input register, state update, result register
// an accepted item is held in the input register, and its status is registered in the result register
// throughput: one item per cycle while out_stall does not hold the result register
// reset: asynchronous, clears sequencer state, pipeline valids, registers to defaults
// depends on fps_pkg and fps_step

module flash_pulse_sequencer_core
    import fps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // item input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  pulse_ms,
    input  logic [7:0]  level_pct,
    input  logic        sync_req,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic        busy_res,
    output logic        sync_line,
    output logic [6:0]  drive_pct,
    output logic [1:0]  phase,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    item_t      item_reg;
    logic       item_valid_reg;
    logic       acc_next;
    logic       advance;

    logic       out_valid_reg;
    logic       accepted_reg;
    logic       busy_reg;
    logic       sync_line_reg;
    logic [6:0] drive_reg;
    logic [1:0] phase_out_reg;

    // pipeline moves when the result register is free or being taken
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = item_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_pulse_ms <= MAX_PULSE_RST;
            cfg_reg.cooldown_ms  <= COOLDOWN_RST;
            cfg_reg.settle_delay <= SETTLE_RST;
            cfg_reg.sync_only_ms <= SYNC_ONLY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_PULSE: cfg_reg.max_pulse_ms <= cfg_data[7:0];
                REG_COOLDOWN:  cfg_reg.cooldown_ms  <= cfg_data;
                REG_SETTLE:    cfg_reg.settle_delay <= cfg_data[7:0];
                REG_SYNC_ONLY: cfg_reg.sync_only_ms <= cfg_data[7:0];
                default:       cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // input item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!in_stall)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.func      <= func;
            item_reg.pulse_ms  <= pulse_ms;
            item_reg.level_pct <= level_pct;
            item_reg.sync_req  <= sync_req;
        end
    end

    fps_step u_step (
        .cur      (state_reg),
        .item     (item_reg),
        .cfg      (cfg_reg),
        .nxt      (state_next),
        .accepted (acc_next)
    );

    // sequencer state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.step_left     <= 8'd0;
            state_reg.pulse_left    <= 8'd0;
            state_reg.cooldown_left <= 16'd0;
            state_reg.level         <= 7'd0;
            state_reg.sync          <= 1'b0;
        end
        else if (advance && item_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
        begin
            accepted_reg  <= acc_next;
            busy_reg      <= (state_next.phase != PH_IDLE);
            sync_line_reg <= state_next.sync;
            drive_reg     <= state_next.level;
            phase_out_reg <= state_next.phase;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign busy_res  = busy_reg;
    assign sync_line = sync_line_reg;
    assign drive_pct = drive_reg;
    assign phase     = phase_out_reg;

    // checks on the sequencer's own logic
    a_drive_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive_pct <= LEVEL_CAP[6:0])
        else $error("drive level above ceiling");

    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy_res == (phase != PH_IDLE))
        else $error("busy flag disagrees with phase");

    a_sync_only_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase == PH_SYNC) |-> drive_pct == 7'd0)
        else $error("leds lit during sync-only pulse");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result side free");

endmodule

[tb/tb_top.sv]
// self-checking testbench for flash_pulse_sequencer_core, with its own sequencer predictor
// depends on fps_pkg and the flash_pulse_sequencer_core rtl
`timescale 1ns / 100ps

module tb_top;
    import fps_pkg::*;

    // the one function code the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic       accepted;
        logic       busy;
        logic       sync;
        logic [6:0] drive;
        logic [1:0] phase;
    } status_t;

    // scoreboard: tracks the sequencer state and the status each item should report
    class flash_scoreboard;
        logic [7:0]  max_pulse;
        logic [15:0] cooldown;
        logic [7:0]  settle;
        logic [7:0]  sync_width;

        logic [1:0]  ph;
        logic [7:0]  step_left;
        logic [7:0]  pulse_left;
        logic [15:0] cool_left;
        logic [6:0]  level;
        logic        sync;

        status_t     due_status[$];
        int          errors;
        int          items_seen;
        int          results_seen;
        int          flashes_started;
        int          sync_pulses_started;

        function new();
            max_pulse = MAX_PULSE_RST;
            cooldown = COOLDOWN_RST;
            settle = SETTLE_RST;
            sync_width = SYNC_ONLY_RST;
            ph = PH_IDLE;
            step_left = '0;
            pulse_left = '0;
            cool_left = '0;
            level = '0;
            sync = 1'b0;
            errors = 0;
            items_seen = 0;
            results_seen = 0;
            flashes_started = 0;
            sync_pulses_started = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_MAX_PULSE: max_pulse = data[7:0];
                REG_COOLDOWN:  cooldown = data;
                REG_SETTLE:    settle = data[7:0];
                REG_SYNC_ONLY: sync_width = data[7:0];
                default: ;
            endcase
        endfunction

        // advance the sequencer by one item and queue the status it reports
        function void note_item(logic [1:0] fn, logic [7:0] len, logic [7:0] pct, logic ws);
            logic       taken;
            logic [7:0] run_len;
            status_t    st;
            taken = 1'b0;
            case (fn)
                FUNC_TICK:
                begin
                    if (cool_left != 0)
                        cool_left = cool_left - 1'b1;
                    case (ph)
                        PH_SETTLE:
                        begin
                            if (step_left != 0)
                                step_left = step_left - 1'b1;
                            if (pulse_left != 0)
                                pulse_left = pulse_left - 1'b1;
                            if (step_left == 0)
                            begin
                                sync = 1'b1;
                                ph = PH_FIRING;
                            end
                        end
                        PH_FIRING:
                        begin
                            if (pulse_left != 0)
                                pulse_left = pulse_left - 1'b1;
                            if (pulse_left == 0)
                            begin
                                level = '0;
                                sync = 1'b0;
                                cool_left = cooldown;
                                ph = PH_IDLE;
                            end
                        end
                        PH_SYNC:
                        begin
                            if (step_left != 0)
                                step_left = step_left - 1'b1;
                            if (step_left == 0)
                            begin
                                sync = 1'b0;
                                ph = PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                FUNC_FIRE:
                begin
                    if (ph == PH_IDLE && cool_left == 0 && len != 0 && pct != 0)
                    begin
                        run_len = (len > max_pulse) ? max_pulse : len;
                        level = (pct > LEVEL_CAP) ? LEVEL_CAP[6:0] : pct[6:0];
                        pulse_left = run_len;
                        if (ws && run_len > settle)
                        begin
                            step_left = settle;
                            ph = PH_SETTLE;
                        end
                        else
                        begin
                            if (ws)
                                sync = 1'b1;
                            ph = PH_FIRING;
                        end
                        taken = 1'b1;
                        flashes_started++;
                    end
                end
                FUNC_SYNC:
                begin
                    // sync-only pulses are not held off by the cooldown
                    if (ph == PH_IDLE)
                    begin
                        sync = 1'b1;
                        step_left = sync_width;
                        ph = PH_SYNC;
                        taken = 1'b1;
                        sync_pulses_started++;
                    end
                end
                default: ;
            endcase
            st.accepted = taken;
            st.busy = (ph != PH_IDLE);
            st.sync = sync;
            st.drive = level;
            st.phase = ph;
            due_status.push_back(st);
            items_seen++;
        endfunction

        function void check_result(status_t got);
            status_t want;
            if (due_status.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: result with nothing expected: ",
                              "acc=%0b busy=%0b sync=%0b drive=%0d phase=%0d"},
                             $time, got.accepted, got.busy, got.sync, got.drive,
                             got.phase);
                return;
            end
            want = due_status.pop_front();
            results_seen++;
            if (got.accepted !== want.accepted || got.busy !== want.busy ||
                got.sync !== want.sync || got.drive !== want.drive ||
                got.phase !== want.phase)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: result %0d mismatch: ",
                              "expected acc=%0b busy=%0b sync=%0b drive=%0d phase=%0d, ",
                              "got acc=%0b busy=%0b sync=%0b drive=%0d phase=%0d"},
                             $time, results_seen, want.accepted, want.busy, want.sync,
                             want.drive, want.phase, got.accepted, got.busy, got.sync,
                             got.drive, got.phase);
            end
        endfunction

        function int outstanding();
            return due_status.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = FUNC_TICK;
    logic [7:0]  pulse_ms = '0;
    logic [7:0]  level_pct = '0;
    logic        sync_req = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic        busy_res;
    logic        sync_line;
    logic [6:0]  drive_pct;
    logic [1:0]  phase;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_MAX_PULSE;
    logic [15:0] cfg_data = '0;

    int gap_pct = 0;
    int stall_pct = 0;
    int settings_used = 0;

    flash_scoreboard sb;

    flash_pulse_sequencer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .pulse_ms  (pulse_ms),
        .level_pct (level_pct),
        .sync_req  (sync_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .accepted  (accepted),
        .busy_res  (busy_res),
        .sync_line (sync_line),
        .drive_pct (drive_pct),
        .phase     (phase),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // random receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // note every item taken by the block
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_item(func, pulse_ms, level_pct, sync_req);
    end

    // check every result taken from the block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{accepted, busy_res, sync_line, drive_pct, phase});
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(logic [7:0] mx, logic [15:0] cd, logic [7:0] st,
                                 logic [7:0] sw);
        write_reg(REG_MAX_PULSE, {8'd0, mx});
        write_reg(REG_COOLDOWN, cd);
        write_reg(REG_SETTLE, {8'd0, st});
        write_reg(REG_SYNC_ONLY, {8'd0, sw});
        settings_used++;
    endtask

    // present one item, with random idle cycles ahead of it
    task automatic send_item(logic [1:0] fn, logic [7:0] len, logic [7:0] pct, logic ws);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        pulse_ms <= len;
        level_pct <= pct;
        sync_req <= ws;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait for every outstanding status
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly ticks and requests with short lengths, some odd values and unused codes
    task automatic random_run(int n);
        int         r;
        logic [1:0] fn;
        logic [7:0] len;
        logic [7:0] pct;
        repeat (n)
        begin
            r = $urandom_range(99);
            fn = (r < 55) ? FUNC_TICK : (r < 80) ? FUNC_FIRE :
                 (r < 93) ? FUNC_SYNC : FUNC_UNUSED;
            r = $urandom_range(99);
            len = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 :
                  (r < 70) ? 8'($urandom_range(1, 12)) : 8'($urandom);
            r = $urandom_range(99);
            pct = (r < 10) ? 8'd0 : (r < 20) ? LEVEL_CAP :
                  (r < 30) ? 8'($urandom_range(101, 255)) : 8'($urandom_range(1, 100));
            send_item(fn, len, pct, 1'($urandom));
        end
        drain();
    endtask

    // watchdog
    initial
    begin
        #1_000_000;
        $display("** flash_pulse_sequencer_core: FAILED **");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: short timings so every phase change shows up quickly
        load_settings(8'd4, 16'd3, 8'd2, 8'd2);
        send_item(FUNC_UNUSED, 8'd255, 8'd255, 1'b1);
        send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_FIRE, 8'd0, 8'd50, 1'b0);
        send_item(FUNC_FIRE, 8'd10, 8'd0, 1'b1);
        // clamped length and level, settle before sync
        send_item(FUNC_FIRE, 8'd255, 8'd255, 1'b1);
        send_item(FUNC_FIRE, 8'd3, 8'd50, 1'b0);
        send_item(FUNC_SYNC, 8'd0, 8'd0, 1'b0);
        repeat (4) send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
        // refused in cooldown, sync-only still allowed
        send_item(FUNC_FIRE, 8'd1, LEVEL_CAP, 1'b0);
        send_item(FUNC_SYNC, 8'd0, 8'd0, 1'b0);
        repeat (3) send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_FIRE, 8'd1, 8'd101, 1'b0);
        repeat (4) send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
        // length not above settle time: sync rises at once
        send_item(FUNC_FIRE, 8'd2, 8'd1, 1'b1);
        send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_TICK, 8'd255, 8'd255, 1'b1);
        drain();

        // random phases across settings and idling modes
        load_settings(8'd8, 16'd4, 8'd3, 8'd4);
        random_run(180);

        gap_pct = 47;
        load_settings(8'd255, 16'd0, 8'd255, 8'd255);
        random_run(180);

        gap_pct = 0;
        stall_pct = 47;
        load_settings(8'd0, 16'd0, 8'd0, 8'd0);
        random_run(180);

        gap_pct = 19;
        stall_pct = 19;
        load_settings(8'd1, 16'd65535, 8'd0, 8'd1);
        random_run(180);

        gap_pct = 47;
        stall_pct = 0;
        load_settings(8'($urandom_range(1, 16)), 16'($urandom_range(0, 20)),
                      8'($urandom_range(0, 10)), 8'($urandom_range(1, 8)));
        random_run(180);

        gap_pct = 0;
        stall_pct = 47;
        load_settings(MAX_PULSE_RST, 16'($urandom_range(0, 12)), SETTLE_RST, SYNC_ONLY_RST);
        random_run(180);

        gap_pct = 0;
        stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("ran %0d items under %0d register settings, %0d statuses checked",
                 sb.items_seen, settings_used, sb.results_seen);
        $display("flashes started %0d, sync-only pulses started %0d, failures %0d",
                 sb.flashes_started, sb.sync_pulses_started, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("** flash_pulse_sequencer_core: PASSED **");
        else
            $display("** flash_pulse_sequencer_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
design/fps_pkg.sv
design/fps_step.sv
design/flash_pulse_sequencer_core.sv
tb/tb_top.sv
